>>> rtl/core/tsv_pkg.sv
// ----------------------------------------------------------------------------
// tsv_pkg
// Shared types, codes and helpers of the tensor shard view calculator.
// ----------------------------------------------------------------------------
package tsv_pkg;

  localparam int MAX_RANK   = 4;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int DIV_STEPS  = 16;
  localparam int MOD_W      = 35;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_VALFAIL = 2'd2;

  // Input kind codes.
  localparam logic [2:0] KIND_Q    = 3'd1;
  localparam logic [2:0] KIND_KV   = 3'd2;
  localparam logic [2:0] KIND_OUT  = 3'd3;
  localparam logic [2:0] KIND_ODIM = 3'd4;
  localparam logic [2:0] KIND_IDIM = 3'd5;
  localparam logic [2:0] KIND_REPL = 3'd6;

  // Shard classes.
  localparam logic [2:0] CLS_UNKNOWN   = 3'd0;
  localparam logic [2:0] CLS_OUT_HEADS = 3'd1;
  localparam logic [2:0] CLS_IN_HEADS  = 3'd2;
  localparam logic [2:0] CLS_OUT_DIM   = 3'd3;
  localparam logic [2:0] CLS_IN_DIM    = 3'd4;
  localparam logic [2:0] CLS_REPL      = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEGREE   = 3'd0;
  localparam logic [2:0] CFG_RANK     = 3'd1;
  localparam logic [2:0] CFG_HEADS    = 3'd2;
  localparam logic [2:0] CFG_Q_BLK    = 3'd3;
  localparam logic [2:0] CFG_KV_BLK   = 3'd4;
  localparam logic [2:0] CFG_OUT_BLK  = 3'd5;

  // One classified request as it waits for the back end.
  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        cls;
    logic              split;
    logic              need_div;
    logic [7:0]        ebytes;
    logic [31:0]       dimlen;
    logic [MOD_W-1:0]  modulus;
    logic [31:0]       ext;
    logic [31:0]       off;
    logic [3:0][31:0]  factors;
  } item_t;

  function automatic logic [2:0] class_of(input logic [2:0] kind);
    logic [2:0] c;
    begin
      case (kind)
        KIND_Q, KIND_KV: c = CLS_OUT_HEADS;
        KIND_OUT:        c = CLS_IN_HEADS;
        KIND_ODIM:       c = CLS_OUT_DIM;
        KIND_IDIM:       c = CLS_IN_DIM;
        KIND_REPL:       c = CLS_REPL;
        default:         c = CLS_UNKNOWN;
      endcase
      return c;
    end
  endfunction

endpackage

>>> rtl/core/tsv_front.sv
// ----------------------------------------------------------------------------
// tsv_front
// Configuration registers and classification of incoming descriptors.
// ----------------------------------------------------------------------------
module tsv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [2:0]          tensor_kind,
  input  logic [2:0]          tensor_rank,
  input  logic [7:0]          element_bytes,
  input  logic [31:0]         dim_size_0,
  input  logic [31:0]         dim_size_1,
  input  logic [31:0]         dim_size_2,
  input  logic [31:0]         dim_size_3,
  output tsv_pkg::item_t      item
);
  import tsv_pkg::*;

  logic [3:0]  degree_r;
  logic [2:0]  rank_r;
  logic [9:0]  heads_r;
  logic [31:0] q_blk_r;
  logic [31:0] kv_blk_r;
  logic [31:0] out_blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r  <= 4'd1;
      rank_r    <= 3'd0;
      heads_r   <= 10'd64;
      q_blk_r   <= 32'd1;
      kv_blk_r  <= 32'd1;
      out_blk_r <= 32'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEGREE:  degree_r  <= cfg_data[3:0];
        CFG_RANK:    rank_r    <= cfg_data[2:0];
        CFG_HEADS:   heads_r   <= cfg_data[9:0];
        CFG_Q_BLK:   q_blk_r   <= cfg_data;
        CFG_KV_BLK:  kv_blk_r  <= cfg_data;
        CFG_OUT_BLK: out_blk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic        deg_ok;
  logic [1:0]  lg;
  logic [31:0] block;
  logic [31:0] dimlen;
  logic [31:0] ext;

  always_comb begin
    unique case (degree_r)
      4'd1: begin deg_ok = 1'b1; lg = 2'd0; end
      4'd2: begin deg_ok = 1'b1; lg = 2'd1; end
      4'd4: begin deg_ok = 1'b1; lg = 2'd2; end
      4'd8: begin deg_ok = 1'b1; lg = 2'd3; end
      default: begin deg_ok = 1'b0; lg = 2'd0; end
    endcase
  end

  always_comb begin
    item          = '0;
    item.cls      = class_of(tensor_kind);
    item.ebytes   = element_bytes;
    item.status   = ST_OK;
    item.split    = (item.cls == CLS_IN_HEADS) || (item.cls == CLS_IN_DIM);
    case (tensor_kind)
      KIND_Q:   block = q_blk_r;
      KIND_KV:  block = kv_blk_r;
      KIND_OUT: block = out_blk_r;
      default:  block = 32'd1;
    endcase
    dimlen = item.split ? dim_size_1 : dim_size_0;
    ext    = dimlen >> lg;

    if (!deg_ok) begin
      item.status = ST_INVALID;
    end else if ({1'b0, rank_r} >= degree_r) begin
      item.status = ST_INVALID;
    end else if (heads_r == 10'd0 || (heads_r[3:0] & (degree_r - 4'd1)) != 4'd0) begin
      item.status = ST_INVALID;
    end else if ({1'b0, tensor_rank} > 4'(MAX_RANK)) begin
      item.status = ST_INVALID;
    end else if (degree_r == 4'd1 || item.cls == CLS_REPL) begin
      // Whole tensor: product of the used dimensions, unused factors are one.
      item.split      = 1'b0;
      item.ext        = dim_size_0;
      item.factors[0] = (tensor_rank > 3'd0) ? dim_size_0 : 32'd1;
      item.factors[1] = (tensor_rank > 3'd1) ? dim_size_1 : 32'd1;
      item.factors[2] = (tensor_rank > 3'd2) ? dim_size_2 : 32'd1;
      item.factors[3] = (tensor_rank > 3'd3) ? dim_size_3 : 32'd1;
    end else if (item.cls == CLS_UNKNOWN) begin
      item.status = ST_VALFAIL;
    end else if (tensor_rank < 3'd2) begin
      item.status = ST_INVALID;
    end else if (block == 32'd0) begin
      item.status = ST_INVALID;
    end else begin
      // Whole blocks shared equally: dimlen must be a multiple of block * degree.
      item.need_div   = 1'b1;
      item.dimlen     = dimlen;
      item.modulus    = {3'd0, block} << lg;
      item.ext        = ext;
      item.off        = 32'(ext * rank_r);
      item.factors[0] = item.split ? dim_size_0 : dim_size_1;
      item.factors[1] = (tensor_rank > 3'd2) ? dim_size_2 : 32'd1;
      item.factors[2] = (tensor_rank > 3'd3) ? dim_size_3 : 32'd1;
      item.factors[3] = ext;
    end
    if (item.status != ST_OK) begin
      item.split = 1'b0;
    end
  end

endmodule

>>> rtl/core/tsv_queue.sv
// ----------------------------------------------------------------------------
// tsv_queue
// Short queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module tsv_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tsv_pkg::item_t  push_data,
  output logic            full,
  input  logic            pop,
  output tsv_pkg::item_t  pop_data,
  output logic            empty
);
  import tsv_pkg::*;

  item_t                mem [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r;
  logic [QPTR_W-1:0]    rd_ptr_r;
  logic [QPTR_W:0]      count_r;

  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/tsv_back.sv
// ----------------------------------------------------------------------------
// tsv_back
// Divisibility check and byte product of one request, then the result stage.
// ----------------------------------------------------------------------------
module tsv_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  tsv_pkg::item_t  q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [2:0]      out_shard_kind,
  output logic            out_split_dim,
  output logic [31:0]     out_slice_offset,
  output logic [31:0]     out_slice_extent,
  output logic [63:0]     out_slice_bytes
);
  import tsv_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

  state_t            state_r;
  item_t             it_r;
  logic [3:0]        cnt_r;
  logic [MOD_W-1:0]  rem_r;
  logic [31:0]       quo_r;
  logic [63:0]       acc_r;
  logic [63:0]       p_r;

  logic [31:0]       factor;
  logic [31:0]       hi_prod;
  logic [MOD_W-1:0]  rem_a;
  logic [MOD_W-1:0]  rem_b;
  logic [1:0]        fin_status;
  logic              slot_free;
  logic              out_valid_nxt;

  // One restoring step; the remainder stays below the modulus.
  function automatic logic [MOD_W-1:0] div_step(input logic [MOD_W-1:0] r,
                                                input logic b,
                                                input logic [MOD_W-1:0] m);
    logic [MOD_W:0] t;
    begin
      t = {r, b};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      return t[MOD_W-1:0];
    end
  endfunction

  assign factor    = it_r.factors[cnt_r[2:1]];
  assign hi_prod   = 32'(acc_r[63:32] * factor);
  assign rem_a     = div_step(rem_r, quo_r[31], it_r.modulus);
  assign rem_b     = div_step(rem_a, quo_r[30], it_r.modulus);
  assign slot_free = !out_valid || out_ready;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;

  // The output register loads from the hold state or keeps an unaccepted result.
  assign out_valid_nxt = ((state_r == S_HOLD) && slot_free) || (out_valid && !out_ready);

  always_comb begin
    if (it_r.status != ST_OK) begin
      fin_status = it_r.status;
    end else if (it_r.need_div && rem_r != '0) begin
      fin_status = ST_INVALID;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      cnt_r     <= '0;
    end else begin
      out_valid <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            it_r    <= q_data;
            cnt_r   <= '0;
            rem_r   <= '0;
            quo_r   <= q_data.dimlen;
            acc_r   <= {56'd0, q_data.ebytes};
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          rem_r <= rem_b;
          quo_r <= {quo_r[29:0], 2'b00};
          // Four factors, each as a low half product, then a high half add.
          if (cnt_r[3] == 1'b0) begin
            if (cnt_r[0] == 1'b0) begin
              p_r <= acc_r[31:0] * factor;
            end else begin
              acc_r <= p_r + {hi_prod, 32'd0};
            end
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(DIV_STEPS - 1)) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (slot_free) begin
            out_status       <= fin_status;
            out_shard_kind   <= it_r.cls;
            if (fin_status == ST_OK) begin
              out_split_dim    <= it_r.split;
              out_slice_offset <= it_r.off;
              out_slice_extent <= it_r.ext;
              out_slice_bytes  <= acc_r;
            end else begin
              out_split_dim    <= 1'b0;
              out_slice_offset <= '0;
              out_slice_extent <= '0;
              out_slice_bytes  <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/tensor_shard_view_calc_top.sv
// ----------------------------------------------------------------------------
// tensor_shard_view_calc_top
// Tensor-parallel shard view of one tensor descriptor per request.
// ----------------------------------------------------------------------------
// A descriptor enters on the in_ channel; one result leaves on the out_
// channel for every request, in order. Configuration registers are written
// on the cfg_ channel (always ready) only while no request is in flight: the
// user must keep to this, the block itself does not enforce it. The front
// classifies a request in the cycle it is accepted and places it in a
// two-entry queue. The back end then takes it from the queue: a
// two-bit-per-cycle remainder unit checks that the split dimension holds
// whole blocks for every rank, while two 32x32 multipliers form the 64-bit
// byte product over four factors, low half then high half for each. The
// result then waits in the hold state and is loaded into the output
// register once that is free. The back end works on one request at a time.
// A new request is taken while a result waits in the output register, until
// the queue is full. When the receiver stalls, the result holds and the back
// end waits with its finished request.
// Reset restores the register defaults and empties queue and output.
// ----------------------------------------------------------------------------
module tensor_shard_view_calc_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_tensor_kind,
  input  logic [2:0]  in_tensor_rank,
  input  logic [7:0]  in_element_bytes,
  input  logic [31:0] in_dim_size_0,
  input  logic [31:0] in_dim_size_1,
  input  logic [31:0] in_dim_size_2,
  input  logic [31:0] in_dim_size_3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [2:0]  out_shard_kind,
  output logic        out_split_dim,
  output logic [31:0] out_slice_offset,
  output logic [31:0] out_slice_extent,
  output logic [63:0] out_slice_bytes
);
  import tsv_pkg::*;

  item_t front_item;
  item_t q_data;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  tsv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .tensor_kind   (in_tensor_kind),
    .tensor_rank   (in_tensor_rank),
    .element_bytes (in_element_bytes),
    .dim_size_0    (in_dim_size_0),
    .dim_size_1    (in_dim_size_1),
    .dim_size_2    (in_dim_size_2),
    .dim_size_3    (in_dim_size_3),
    .item          (front_item)
  );

  tsv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_data (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  tsv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_shard_kind   (out_shard_kind),
    .out_split_dim    (out_split_dim),
    .out_slice_offset (out_slice_offset),
    .out_slice_extent (out_slice_extent),
    .out_slice_bytes  (out_slice_bytes)
  );

  // A request just accepted must be waiting in the queue.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !q_empty)
    else $error("accepted request missing from queue");

  // A failed request carries no slice.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_slice_bytes == 64'd0 && out_slice_extent == 32'd0 &&
       out_slice_offset == 32'd0 && !out_split_dim))
    else $error("error result carries slice data");

  // Only input-side classes split dimension one.
  a_split_cls: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_split_dim) |->
      (out_shard_kind == CLS_IN_HEADS || out_shard_kind == CLS_IN_DIM))
    else $error("split dimension does not match class");

endmodule

>>> sim/tensor_shard_view_calc_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tensor_shard_view_calc_top_test
// Self-checking test of the tensor shard view calculator.
// ----------------------------------------------------------------------------
// Descriptors are sent in random bursts while the receiver stalls on its own
// pattern. Every accepted request is run through a local model of the shard
// rules, and each result is checked in order against that prediction.
// Register settings change between phases and cover the valid degrees, the
// broken ones, zero and full-width block sizes.
// ----------------------------------------------------------------------------
module tensor_shard_view_calc_top_test;
  import tsv_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1880;

  typedef struct {
    logic [2:0]       kind;
    logic [2:0]       rank;
    logic [7:0]       ebytes;
    logic [3:0][31:0] dims;
  } desc_t;

  typedef struct {
    logic [1:0]  status;
    logic [2:0]  cls;
    logic        split;
    logic [31:0] off;
    logic [31:0] ext;
    logic [63:0] bytes;
  } shard_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_tensor_kind;
  logic [2:0]  in_tensor_rank;
  logic [7:0]  in_element_bytes;
  logic [31:0] in_dim_size_0;
  logic [31:0] in_dim_size_1;
  logic [31:0] in_dim_size_2;
  logic [31:0] in_dim_size_3;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [2:0]  out_shard_kind;
  logic        out_split_dim;
  logic [31:0] out_slice_offset;
  logic [31:0] out_slice_extent;
  logic [63:0] out_slice_bytes;

  // Local copy of the register file.
  logic [3:0]  reg_degree;
  logic [2:0]  reg_rank;
  logic [9:0]  reg_heads;
  logic [31:0] reg_q_blk;
  logic [31:0] reg_kv_blk;
  logic [31:0] reg_out_blk;

  shard_t expected_shards[$];
  int     mismatches;
  int     sent_count;
  int     result_count;
  int     cfg_count;
  int     ok_count;
  int     idle_cycles;
  int     burst_left;
  int     stall_mode;
  int     stall_left;

  tensor_shard_view_calc_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_tensor_kind   (in_tensor_kind),
    .in_tensor_rank   (in_tensor_rank),
    .in_element_bytes (in_element_bytes),
    .in_dim_size_0    (in_dim_size_0),
    .in_dim_size_1    (in_dim_size_1),
    .in_dim_size_2    (in_dim_size_2),
    .in_dim_size_3    (in_dim_size_3),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_shard_kind   (out_shard_kind),
    .out_split_dim    (out_split_dim),
    .out_slice_offset (out_slice_offset),
    .out_slice_extent (out_slice_extent),
    .out_slice_bytes  (out_slice_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [2:0] decode_kind(input logic [2:0] kind);
    case (kind)
      KIND_Q, KIND_KV: return CLS_OUT_HEADS;
      KIND_OUT:        return CLS_IN_HEADS;
      KIND_ODIM:       return CLS_OUT_DIM;
      KIND_IDIM:       return CLS_IN_DIM;
      KIND_REPL:       return CLS_REPL;
      default:         return CLS_UNKNOWN;
    endcase
  endfunction

  function automatic shard_t predict_shard(input desc_t r);
    shard_t      s;
    logic [63:0] deg;
    logic [63:0] blk;
    logic [63:0] dimlen;
    logic [63:0] cnt;
    logic [63:0] span;
    logic [63:0] prod;
    logic        split;
    s = '{default: '0};
    s.cls = decode_kind(r.kind);
    deg = 64'(reg_degree);
    if (deg != 1 && deg != 2 && deg != 4 && deg != 8) begin
      s.status = ST_INVALID;
    end else if (64'(reg_rank) >= deg) begin
      s.status = ST_INVALID;
    end else if (reg_heads == 0 || 64'(reg_heads) % deg != 0) begin
      s.status = ST_INVALID;
    end else if (r.rank > MAX_RANK) begin
      s.status = ST_INVALID;
    end else if (deg == 1 || s.cls == CLS_REPL) begin
      prod = 64'(r.ebytes);
      for (int d = 0; d < r.rank; d++) prod = prod * 64'(r.dims[d]);
      s.bytes = prod;
      s.ext = r.dims[0];
    end else if (s.cls == CLS_UNKNOWN) begin
      s.status = ST_VALFAIL;
    end else if (r.rank < 2) begin
      s.status = ST_INVALID;
    end else begin
      split = (s.cls == CLS_IN_HEADS || s.cls == CLS_IN_DIM);
      case (r.kind)
        KIND_Q:   blk = 64'(reg_q_blk);
        KIND_KV:  blk = 64'(reg_kv_blk);
        KIND_OUT: blk = 64'(reg_out_blk);
        default:  blk = 64'd1;
      endcase
      dimlen = 64'(r.dims[split]);
      if (blk == 0 || dimlen % blk != 0) begin
        s.status = ST_INVALID;
      end else begin
        cnt = dimlen / blk;
        if (cnt % deg != 0) begin
          s.status = ST_INVALID;
        end else begin
          span = (cnt / deg) * blk;
          s.split = split;
          s.ext = span[31:0];
          prod = 64'(reg_rank) * span;
          s.off = prod[31:0];
          prod = 64'(r.ebytes);
          for (int d = 0; d < r.rank; d++) begin
            if (d != split) prod = prod * 64'(r.dims[d]);
          end
          s.bytes = prod * span;
        end
      end
    end
    return s;
  endfunction

  // Sender: bursts of random length with random gaps in between.
  task automatic send_desc(input desc_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid         <= 1'b1;
    in_tensor_kind   <= r.kind;
    in_tensor_rank   <= r.rank;
    in_element_bytes <= r.ebytes;
    in_dim_size_0    <= r.dims[0];
    in_dim_size_1    <= r.dims[1];
    in_dim_size_2    <= r.dims[2];
    in_dim_size_3    <= r.dims[3];
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    expected_shards.push_back(predict_shard(r));
    sent_count++;
    burst_left--;
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_shards.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_count++;
    case (idx)
      CFG_DEGREE:  reg_degree  = data[3:0];
      CFG_RANK:    reg_rank    = data[2:0];
      CFG_HEADS:   reg_heads   = data[9:0];
      CFG_Q_BLK:   reg_q_blk   = data;
      CFG_KV_BLK:  reg_kv_blk  = data;
      CFG_OUT_BLK: reg_out_blk = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [3:0] deg, input logic [2:0] rk, input logic [9:0] heads,
                          input logic [31:0] qb, input logic [31:0] kvb, input logic [31:0] ob);
    wait_drained();
    write_reg(CFG_DEGREE, {$urandom} & 32'hFFFF_FFF0 | 32'(deg));
    write_reg(CFG_RANK, {$urandom} & 32'hFFFF_FFF8 | 32'(rk));
    write_reg(CFG_HEADS, {$urandom} & 32'hFFFF_FC00 | 32'(heads));
    write_reg(CFG_Q_BLK, qb);
    write_reg(CFG_KV_BLK, kvb);
    write_reg(CFG_OUT_BLK, ob);
  endtask

  function automatic desc_t make_desc(input logic [2:0] kind, input logic [2:0] rank,
                                      input logic [7:0] eb, input logic [31:0] d0,
                                      input logic [31:0] d1, input logic [31:0] d2,
                                      input logic [31:0] d3);
    desc_t r;
    r.kind = kind;
    r.rank = rank;
    r.ebytes = eb;
    r.dims = {d3, d2, d1, d0};
    return r;
  endfunction

  // Mostly descriptors that split cleanly under the current registers,
  // with some that are corrupted or fully random.
  function automatic desc_t random_desc;
    desc_t       r;
    logic [31:0] blk;
    int          pick;
    r.kind = 3'($urandom_range(0, 7));
    r.rank = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(2, 4));
    r.ebytes = 8'($urandom);
    for (int d = 0; d < 4; d++) begin
      pick = $urandom_range(0, 9);
      r.dims[d] = (pick == 0) ? 32'($urandom) : (pick == 1) ? 32'hFFFF_FFFF
                : 32'($urandom_range(1, 4096));
    end
    case (r.kind)
      KIND_Q:   blk = reg_q_blk;
      KIND_KV:  blk = reg_kv_blk;
      KIND_OUT: blk = reg_out_blk;
      default:  blk = 32'd1;
    endcase
    if ($urandom_range(0, 9) < 7) begin
      for (int d = 0; d < 2; d++) begin
        r.dims[d] = blk * 32'(reg_degree) * 32'($urandom_range(1, 40));
      end
      if ($urandom_range(0, 9) == 0) r.dims[$urandom_range(0, 1)] += 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] random_block;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 32'd0;
    if (pick == 1) return 32'hFFFF_FFFF;
    if (pick == 2) return $urandom;
    return 32'($urandom_range(1, 16));
  endfunction

  task automatic test_reset_defaults;
    for (int k = 0; k < 8; k++) begin
      send_desc(make_desc(3'(k), 3'(k % 5), 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
    end
    send_desc(make_desc(KIND_REPL, 3'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send_desc(make_desc(KIND_REPL, 3'd5, 8'd7, 32'd3, 32'd5, 32'd7, 32'd9));
  endtask

  task automatic test_register_checks;
    set_regs(4'd3, 3'd0, 10'd64, 32'd1, 32'd1, 32'd1);
    send_desc(make_desc(KIND_REPL, 3'd2, 8'd2, 32'd8, 32'd8, 32'd0, 32'd0));
    set_regs(4'd0, 3'd0, 10'd64, 32'd1, 32'd1, 32'd1);
    send_desc(make_desc(KIND_ODIM, 3'd2, 8'd2, 32'd8, 32'd8, 32'd0, 32'd0));
    set_regs(4'd15, 3'd7, 10'd1023, 32'd1, 32'd1, 32'd1);
    send_desc(make_desc(KIND_ODIM, 3'd2, 8'd2, 32'd8, 32'd8, 32'd0, 32'd0));
    set_regs(4'd4, 3'd4, 10'd64, 32'd1, 32'd1, 32'd1);
    send_desc(make_desc(KIND_ODIM, 3'd2, 8'd2, 32'd8, 32'd8, 32'd0, 32'd0));
    set_regs(4'd4, 3'd3, 10'd0, 32'd1, 32'd1, 32'd1);
    send_desc(make_desc(KIND_ODIM, 3'd2, 8'd2, 32'd8, 32'd8, 32'd0, 32'd0));
    set_regs(4'd8, 3'd3, 10'd12, 32'd1, 32'd1, 32'd1);
    send_desc(make_desc(KIND_ODIM, 3'd2, 8'd2, 32'd8, 32'd8, 32'd0, 32'd0));
    // Writes to the unused indexes must leave every register alone.
    wait_drained();
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h0);
    send_desc(make_desc(KIND_ODIM, 3'd7, 8'd2, 32'd8, 32'd8, 32'd0, 32'd0));
  endtask

  task automatic test_split_cases;
    set_regs(4'd8, 3'd7, 10'd1016, 32'd0, 32'd3, 32'hFFFF_FFFF);
    send_desc(make_desc(KIND_Q, 3'd2, 8'd4, 32'd64, 32'd16, 32'd0, 32'd0));
    send_desc(make_desc(KIND_KV, 3'd3, 8'd2, 32'd48, 32'd5, 32'd6, 32'd0));
    send_desc(make_desc(KIND_KV, 3'd2, 8'd2, 32'd47, 32'd5, 32'd6, 32'd0));
    send_desc(make_desc(KIND_KV, 3'd2, 8'd2, 32'd12, 32'd5, 32'd6, 32'd0));
    send_desc(make_desc(KIND_OUT, 3'd4, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_desc(make_desc(KIND_ODIM, 3'd1, 8'd1, 32'd64, 32'd0, 32'd0, 32'd0));
    send_desc(make_desc(3'd0, 3'd2, 8'd1, 32'd64, 32'd64, 32'd0, 32'd0));
    send_desc(make_desc(3'd7, 3'd2, 8'd1, 32'd64, 32'd64, 32'd0, 32'd0));
    send_desc(make_desc(KIND_IDIM, 3'd4, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFF8,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_desc(make_desc(KIND_REPL, 3'd4, 8'd3, 32'd10, 32'd0, 32'd5, 32'd5));
  endtask

  task automatic test_random_traffic;
    int          per_phase;
    logic [3:0]  deg;
    logic [2:0]  rk;
    logic [9:0]  heads;
    per_phase = RANDOM_ITEMS / 8;
    for (int ph = 0; ph < 8; ph++) begin
      deg = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'(1 << $urandom_range(0, 3));
      rk = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, deg - 1));
      heads = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'(8 * $urandom_range(1, 127));
      set_regs(deg, rk, heads, random_block(), random_block(), random_block());
      for (int i = 0; i < per_phase; i++) begin
        send_desc(random_desc());
        // Hold the sender once per phase until the pipe has emptied.
        if (i == per_phase / 2) wait_drained();
      end
    end
  endtask

  // Receiver: stall pattern with free-running, light and heavy stretches.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Results are checked on the falling edge before the rising edge that accepts them.
  always @(negedge clk) begin
    shard_t exp_s;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (expected_shards.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no request outstanding");
      end else begin
        exp_s = expected_shards.pop_front();
        if (exp_s.status == ST_OK) ok_count++;
        if (out_status !== exp_s.status || out_shard_kind !== exp_s.cls ||
            out_split_dim !== exp_s.split || out_slice_offset !== exp_s.off ||
            out_slice_extent !== exp_s.ext || out_slice_bytes !== exp_s.bytes) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d expected st=%0d cls=%0d dim=%0d off=%0h ext=%0h bytes=%0h",
                     result_count, exp_s.status, exp_s.cls, exp_s.split, exp_s.off,
                     exp_s.ext, exp_s.bytes);
            $display("       actual        st=%0d cls=%0d dim=%0d off=%0h ext=%0h bytes=%0h",
                     out_status, out_shard_kind, out_split_dim, out_slice_offset,
                     out_slice_extent, out_slice_bytes);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no channel makes a transfer.
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_shards.size());
        $display("tensor_shard_view_calc_top_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_tensor_kind   <= '0;
    in_tensor_rank   <= '0;
    in_element_bytes <= '0;
    in_dim_size_0    <= '0;
    in_dim_size_1    <= '0;
    in_dim_size_2    <= '0;
    in_dim_size_3    <= '0;
    out_ready        <= 1'b0;
    stall_mode = 0;
    stall_left = 0;
    mismatches = 0;
    sent_count = 0;
    result_count = 0;
    cfg_count = 0;
    ok_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    reg_degree = 4'd1;
    reg_rank = 3'd0;
    reg_heads = 10'd64;
    reg_q_blk = 32'd1;
    reg_kv_blk = 32'd1;
    reg_out_blk = 32'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_checks();
    test_split_cases();
    test_random_traffic();

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d descriptors over %0d register writes; %0d results, %0d with status ok.",
             sent_count, cfg_count, result_count, ok_count);
    if (mismatches == 0 && expected_shards.size() == 0) begin
      $display("tensor_shard_view_calc_top_test OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_shards.size());
      $display("tensor_shard_view_calc_top_test NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tsv_pkg.sv
rtl/core/tsv_front.sv
rtl/core/tsv_queue.sv
rtl/core/tsv_back.sv
rtl/core/tensor_shard_view_calc_top.sv
sim/tensor_shard_view_calc_top_test.sv
